// ===== hdl/mrfc_pkg.sv =====
package mrfc_pkg;

    localparam int WORD_W    = 32;
    localparam int OUT_WORDS = 8;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_BAD_CRC  = 3'd2,
        ST_ZERO     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_KEEP    = 2'd1,
        ACT_DISCARD = 2'd2,
        ACT_TRIP    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_DEVICE_ID     = 3'd0,
        REG_VOLTAGE_LIMIT = 3'd1,
        REG_CURRENT_LIMIT = 3'd2,
        REG_PF_MINIMUM    = 3'd3,
        REG_FREQ_LOW      = 3'd4,
        REG_FREQ_HIGH     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]        device_id;
        logic [WORD_W-1:0] voltage_limit;
        logic [WORD_W-1:0] current_limit;
        logic [9:0]        pf_minimum;
        logic [15:0]       freq_low;
        logic [15:0]       freq_high;
    } cfg_t;

    typedef struct packed {
        logic last;
        logic id_ok;
        logic crc_ok;
    } frame_flags_t;

    typedef logic [OUT_WORDS-1:0][WORD_W-1:0] out_words_t;

    // Modbus CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int n = 0; n < 8; n++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mrfc_frame_track.sv =====
module mrfc_frame_track #(
    parameter int FRAME_BYTES = 37,
    parameter int WORD_COUNT  = 8
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic [7:0]                                    rx_byte,
    input  logic                                          frame_start,
    input  logic [7:0]                                    device_id,
    output mrfc_pkg::frame_flags_t                        flags,
    output logic [WORD_COUNT-1:0][mrfc_pkg::WORD_W-1:0]   words
);
    import mrfc_pkg::*;

    localparam int CNT_W    = $clog2(FRAME_BYTES);
    localparam int IDX_W    = $clog2(WORD_COUNT);
    localparam int CRC_LO   = FRAME_BYTES - 2;
    localparam int LAST     = FRAME_BYTES - 1;
    localparam int WORD_END = 3 + 4 * WORD_COUNT;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic             id_ok_reg, id_ok_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic [WORD_COUNT-1:0][WORD_W-1:0] words_reg, words_next;

    logic [CNT_W-1:0] pos;
    logic [31:0]      pos_ext;
    logic [31:0]      word_ofs;
    logic [IDX_W-1:0] word_idx;
    logic             in_body;
    logic             in_word;
    logic             is_last;

    assign pos      = frame_start ? '0 : count_reg;
    assign pos_ext  = 32'(pos);
    assign word_ofs = pos_ext - 32'd3;
    assign word_idx = word_ofs[IDX_W+1:2];
    assign in_body  = pos_ext < 32'(CRC_LO);
    assign in_word  = in_body && (pos_ext >= 32'd3) && (pos_ext < 32'(WORD_END));
    assign is_last  = pos_ext == 32'(LAST);

    always_comb begin
        count_next   = is_last ? '0 : pos + CNT_W'(1);
        crc_next     = crc_reg;
        id_ok_next   = id_ok_reg;
        crc_low_next = crc_low_reg;
        words_next   = words_reg;
        if (pos == '0) begin
            words_next = '0;
            id_ok_next = (rx_byte == device_id);
            crc_next   = crc_update(CRC_INIT, rx_byte);
        end else if (in_body) begin
            crc_next = crc_update(crc_reg, rx_byte);
        end
        if (in_word) begin
            words_next[word_idx] = {words_reg[word_idx][WORD_W-9:0], rx_byte};
        end
        if (pos_ext == 32'(CRC_LO)) begin
            crc_low_next = rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            id_ok_reg   <= 1'b0;
            crc_low_reg <= 8'h00;
        end else if (en) begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            id_ok_reg   <= id_ok_next;
            crc_low_reg <= crc_low_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            words_reg <= words_next;
        end
    end

    assign flags.last   = is_last;
    assign flags.id_ok  = id_ok_reg;
    assign flags.crc_ok = (crc_reg[7:0] == crc_low_reg) && (crc_reg[15:8] == rx_byte);
    assign words        = words_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) < 32'(FRAME_BYTES))
        else $error("byte count beyond frame length");

    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        en && is_last |=> count_reg == '0)
        else $error("byte count did not wrap after last byte");

endmodule

// ===== hdl/mrfc_verdict.sv =====
module mrfc_verdict (
    input  mrfc_pkg::frame_flags_t flags,
    input  mrfc_pkg::out_words_t   words,
    input  mrfc_pkg::cfg_t         cfg,
    output mrfc_pkg::status_t      status,
    output mrfc_pkg::action_t      action
);
    import mrfc_pkg::*;

    logic zero_any;
    logic range_bad;

    assign zero_any  = (words[0] == '0) || (words[1] == '0) ||
                       (words[2] == '0) || (words[3] == '0);
    assign range_bad = (words[6] == '0) ||
                       !(words[7] > {16'h0000, cfg.freq_low}) ||
                       !(words[7] < {16'h0000, cfg.freq_high});

    always_comb begin
        if (!flags.id_ok) begin
            status = ST_BAD_ID;
        end else if (!flags.crc_ok) begin
            status = ST_BAD_CRC;
        end else if (zero_any) begin
            status = ST_ZERO;
        end else if (range_bad) begin
            status = ST_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        if (status != ST_OK) begin
            action = ACT_NONE;
        end else if ((words[0] >= cfg.voltage_limit) || (words[1] >= cfg.current_limit)) begin
            action = ACT_TRIP;
        end else if (words[4] < {22'h000000, cfg.pf_minimum}) begin
            action = ACT_DISCARD;
        end else begin
            action = ACT_KEEP;
        end
    end

endmodule

// ===== hdl/meter_response_frame_checker.sv =====
// Meter reply checker: takes a fixed-length power-meter reply one byte per
// request on the s_ channel (s_frame_start marks byte 0) and gives one result
// on the m_ channel after the last byte: status, safety action and the eight
// assembled 32-bit readings. Bytes that are not the last give no result.
// Checks run in order: device address, Modbus CRC-16 over all but the last
// two bytes, zero in the first four readings, temperature and frequency
// range. Good frames trip on voltage or current limit, else discard on low
// power factor, else keep.
// A byte is held in the input register and is folded into the frame state
// on the edge on which it advances; the result register loads on that same
// edge, so m_valid rises once the last byte leaves the input register.
// Throughput is one byte per cycle while the output is not stalled.
// Limits are written through cfg_we/cfg_addr/cfg_wdata, which the user must
// do only while no reply is in flight; the block does not enforce it. Unknown
// indexes are dropped. Reset clears the byte count and both valid flags,
// presets the CRC and restores the register defaults. A stalled result holds
// the output register; bytes keep flowing until the next last byte finds the
// output still full, then the input register holds and s_ready drops.
module meter_response_frame_checker #(
    parameter int FRAME_BYTES = 37,
    parameter int WORD_COUNT  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_action,
    output logic [31:0] m_voltage,
    output logic [31:0] m_current,
    output logic [31:0] m_active_power,
    output logic [31:0] m_energy,
    output logic [31:0] m_power_factor,
    output logic [31:0] m_carbon,
    output logic [31:0] m_temperature,
    output logic [31:0] m_frequency
);
    import mrfc_pkg::*;

    cfg_t cfg_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       out_valid_reg, out_valid_next;
    status_t    status_reg;
    action_t    action_reg;
    out_words_t words_out_reg;

    logic         advance;
    frame_flags_t flags;
    logic [WORD_COUNT-1:0][WORD_W-1:0] words;
    out_words_t   words8;
    status_t      status;
    action_t      action;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_id     <= 8'd1;
            cfg_reg.voltage_limit <= 32'd2600000;
            cfg_reg.current_limit <= 32'd200000;
            cfg_reg.pf_minimum    <= 10'd100;
            cfg_reg.freq_low      <= 16'd4800;
            cfg_reg.freq_high     <= 16'd5100;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEVICE_ID:     cfg_reg.device_id     <= cfg_wdata[7:0];
                REG_VOLTAGE_LIMIT: cfg_reg.voltage_limit <= cfg_wdata;
                REG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_wdata;
                REG_PF_MINIMUM:    cfg_reg.pf_minimum    <= cfg_wdata[9:0];
                REG_FREQ_LOW:      cfg_reg.freq_low      <= cfg_wdata[15:0];
                REG_FREQ_HIGH:     cfg_reg.freq_high     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // advance the held byte unless a last byte would hit a full output
    assign advance = in_valid_reg && (!out_valid_reg || m_ready || !flags.last);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && flags.last) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_frame_start;
        end
        if (advance && flags.last) begin
            status_reg    <= status;
            action_reg    <= action;
            words_out_reg <= words8;
        end
    end

    mrfc_frame_track #(
        .FRAME_BYTES (FRAME_BYTES),
        .WORD_COUNT  (WORD_COUNT)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .device_id   (cfg_reg.device_id),
        .flags       (flags),
        .words       (words)
    );

    // readings past the configured count read as zero
    for (genvar k = 0; k < OUT_WORDS; k++) begin : g_words
        if (k < WORD_COUNT) begin : g_used
            assign words8[k] = words[k];
        end else begin : g_absent
            assign words8[k] = '0;
        end
    end

    mrfc_verdict u_verdict (
        .flags  (flags),
        .words  (words8),
        .cfg    (cfg_reg),
        .status (status),
        .action (action)
    );

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_action       = action_reg;
    assign m_voltage      = words_out_reg[0];
    assign m_current      = words_out_reg[1];
    assign m_active_power = words_out_reg[2];
    assign m_energy       = words_out_reg[3];
    assign m_power_factor = words_out_reg[4];
    assign m_carbon       = words_out_reg[5];
    assign m_temperature  = words_out_reg[6];
    assign m_frequency    = words_out_reg[7];

    a_action_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((status_reg == ST_OK) == (action_reg != ACT_NONE)))
        else $error("action disagrees with status");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready && flags.last))
        else $error("input stalled without a blocked result");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg ##1 out_valid_reg |-> $past(advance && flags.last))
        else $error("result raised without a last byte");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mrfc_pkg::*;

    localparam int FRAME_BYTES = 37;
    localparam int WORD_COUNT  = 8;
    localparam int PHASES      = 9;
    localparam int PHASE_BYTES = 30;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef enum int {F_GOOD, F_BAD_ID, F_BAD_CRC, F_ZERO, F_RANGE} frame_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       drain;   // hold this request until every reply is back
    } rx_req_t;

    typedef struct packed {
        status_t    status;
        action_t    action;
        out_words_t words;
    } meter_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_frame_start;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [1:0]  m_action;
    logic [31:0] m_voltage;
    logic [31:0] m_current;
    logic [31:0] m_active_power;
    logic [31:0] m_energy;
    logic [31:0] m_power_factor;
    logic [31:0] m_carbon;
    logic [31:0] m_temperature;
    logic [31:0] m_frequency;

    meter_response_frame_checker dut (.*);

    always #1 aclk = ~aclk;

    string word_name [OUT_WORDS] = '{"voltage", "current", "active_power", "energy",
                                     "power_factor", "carbon", "temperature", "frequency"};

    // register mirror and frame state of the expected behavior
    cfg_t        regs;
    int          rx_pos;
    logic [15:0] frame_crc;
    out_words_t  frame_words;
    logic        addr_match;
    logic [7:0]  crc_lo;

    rx_req_t      rx_pending [$];
    meter_reply_t expected_replies [$];

    int unsigned gap_max;
    int unsigned stall_max;
    int unsigned send_gap;
    int unsigned recv_stall;
    int          rx_pushed;
    int          mismatches;
    bit          on_boundary;
    bit          byte_taken;
    bit          reply_taken;

    // Modbus CRC, one bit at a time, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c;
        for (int i = 0; i < 8; i++) begin
            x = {1'b0, x[15:1]} ^ ((x[0] ^ d[i]) ? CRC_POLY : 16'h0000);
        end
        return x;
    endfunction

    function automatic void fold_rx_byte(input logic [7:0] b, input logic start);
        int           pos;
        int           widx;
        meter_reply_t r;
        if (start) begin
            rx_pos = 0;
        end
        pos = rx_pos;
        if (pos == 0) begin
            frame_crc   = CRC_INIT;
            frame_words = '0;
            addr_match  = (b == regs.device_id);
        end
        if (pos < FRAME_BYTES - 2) begin
            frame_crc = crc_byte(frame_crc, b);
            if (pos >= 3 && pos < 3 + 4 * WORD_COUNT) begin
                widx = (pos - 3) / 4;
                frame_words[widx] = {frame_words[widx][23:0], b};
            end
            rx_pos = pos + 1;
        end else if (pos == FRAME_BYTES - 2) begin
            crc_lo = b;
            rx_pos = pos + 1;
        end else begin
            rx_pos  = 0;
            r.words = frame_words;
            if (!addr_match) begin
                r.status = ST_BAD_ID;
            end else if (frame_crc[7:0] != crc_lo || frame_crc[15:8] != b) begin
                r.status = ST_BAD_CRC;
            end else if (r.words[0] == 0 || r.words[1] == 0 || r.words[2] == 0 ||
                         r.words[3] == 0) begin
                r.status = ST_ZERO;
            end else if (r.words[6] == 0 || !(r.words[7] > regs.freq_low) ||
                         !(r.words[7] < regs.freq_high)) begin
                r.status = ST_RANGE;
            end else begin
                r.status = ST_OK;
            end
            if (r.status != ST_OK) begin
                r.action = ACT_NONE;
            end else if (r.words[0] >= regs.voltage_limit ||
                         r.words[1] >= regs.current_limit) begin
                r.action = ACT_TRIP;
            end else if (r.words[4] < regs.pf_minimum) begin
                r.action = ACT_DISCARD;
            end else begin
                r.action = ACT_KEEP;
            end
            expected_replies.push_back(r);
        end
    endfunction

    function automatic logic [31:0] near_limit(input logic [31:0] lim);
        case ($urandom_range(0, 6))
            0: return lim - 32'd1;
            1: return lim;
            2: return lim + 32'd1;
            3: return 32'hFFFF_FFFF;
            4: return 32'd1;
            5: return (lim == 0) ? 32'd0 : $urandom_range(0, lim - 1);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEVICE_ID:     regs.device_id     = val[7:0];
            REG_VOLTAGE_LIMIT: regs.voltage_limit = val;
            REG_CURRENT_LIMIT: regs.current_limit = val;
            REG_PF_MINIMUM:    regs.pf_minimum    = val[9:0];
            REG_FREQ_LOW:      regs.freq_low      = val[15:0];
            REG_FREQ_HIGH:     regs.freq_high     = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_frame(input logic [7:0] addr, input out_words_t w,
                              input logic [15:0] flip, input bit start, input bit drain,
                              input int len);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] crc;
        rx_req_t     req;
        fb[0] = addr;
        fb[1] = 8'($urandom());
        fb[2] = 8'($urandom());
        for (int k = 0; k < WORD_COUNT; k++) begin
            for (int j = 0; j < 4; j++) begin
                fb[3 + 4 * k + j] = w[k][31 - 8 * j -: 8];
            end
        end
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            crc = crc_byte(crc, fb[i]);
        end
        crc = crc ^ flip;
        fb[FRAME_BYTES - 2] = crc[7:0];
        fb[FRAME_BYTES - 1] = crc[15:8];
        for (int i = 0; i < len; i++) begin
            req.data  = fb[i];
            req.start = (i == 0) && start;
            req.drain = (i == 0) && drain;
            rx_pending.push_back(req);
        end
        rx_pushed   += len;
        on_boundary = (len == FRAME_BYTES);
    endtask

    task automatic push_random_frame(input frame_kind_t kind, input int len);
        out_words_t  w;
        logic [7:0]  addr;
        logic [15:0] flip;
        bit          start;
        addr  = regs.device_id;
        flip  = 16'h0000;
        // a frame that follows a complete one may rely on the count wrapping
        start = on_boundary ? ($urandom_range(0, 3) != 0) : 1'b1;
        w[0] = near_limit(regs.voltage_limit);
        w[1] = near_limit(regs.current_limit);
        w[2] = $urandom();
        w[3] = $urandom();
        w[4] = near_limit({22'd0, regs.pf_minimum});
        w[5] = $urandom();
        w[6] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 12000);
        if (regs.freq_high > regs.freq_low + 1) begin
            case ($urandom_range(0, 3))
                0: w[7] = regs.freq_low + 1;
                1: w[7] = regs.freq_high - 1;
                default: w[7] = $urandom_range(regs.freq_low + 1, regs.freq_high - 1);
            endcase
        end else begin
            w[7] = $urandom_range(0, 65535);
        end
        for (int k = 0; k < 4; k++) begin
            if (w[k] == 0) begin
                w[k] = 32'd1;
            end
        end
        case (kind)
            F_BAD_ID:  addr = regs.device_id ^ 8'($urandom_range(1, 255));
            F_BAD_CRC: flip = 16'd1 << $urandom_range(0, 15);
            F_ZERO:    w[$urandom_range(0, 3)] = 32'd0;
            F_RANGE: begin
                case ($urandom_range(0, 3))
                    0: w[6] = 32'd0;
                    1: w[7] = regs.freq_low;
                    2: w[7] = regs.freq_high;
                    default: w[7][31:16] = 16'($urandom_range(1, 65535));
                endcase
            end
            default: ;
        endcase
        push_frame(addr, w, flip, start, $urandom_range(0, 7) == 0, len);
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || s_valid || expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        // let a byte still in the pipeline settle before touching registers
        repeat (6) @(posedge aclk);
    endtask

    // sample both handshakes, predict and check
    always @(posedge aclk) begin : sample
        meter_reply_t want;
        out_words_t   got;
        byte_taken  = aresetn && s_valid && s_ready;
        reply_taken = aresetn && m_valid && m_ready;
        if (byte_taken) begin
            fold_rx_byte(s_rx_byte, s_frame_start);
        end
        if (reply_taken) begin
            got = {m_frequency, m_temperature, m_carbon, m_power_factor,
                   m_energy, m_active_power, m_current, m_voltage};
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: status %0d action %0d", m_status, m_action);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_action);
                    mismatches++;
                end
                for (int k = 0; k < OUT_WORDS; k++) begin
                    if (got[k] !== want.words[k]) begin
                        $error("%s: expected %0h, got %0h", word_name[k], want.words[k], got[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // byte sender and reply receiver
    always @(negedge aclk) begin : drive
        rx_req_t nxt;
        if (aresetn) begin
            if (!s_valid || byte_taken) begin
                if (byte_taken) begin
                    send_gap = $urandom_range(0, gap_max);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (rx_pending.size() != 0 &&
                             !(rx_pending[0].drain && expected_replies.size() != 0)) begin
                    nxt = rx_pending.pop_front();
                    s_valid       <= 1'b1;
                    s_rx_byte     <= nxt.data;
                    s_frame_start <= nxt.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (reply_taken) begin
                recv_stall = $urandom_range(0, stall_max);
            end
            m_ready <= (recv_stall == 0);
            if (recv_stall > 0 && m_valid) begin
                recv_stall--;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("meter_response_frame_checker regression: fail");
        $finish;
    end

    initial begin : stimulus
        out_words_t  base;
        out_words_t  w;
        rx_req_t     req;
        int          phase_start;
        int          n;
        int unsigned lo;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_rx_byte     = '0;
        s_frame_start = 1'b0;
        m_ready       = 1'b0;
        regs          = '{device_id: 8'd1, voltage_limit: 32'd2600000,
                          current_limit: 32'd200000, pf_minimum: 10'd100,
                          freq_low: 16'd4800, freq_high: 16'd5100};
        rx_pos        = 0;
        frame_crc     = CRC_INIT;
        frame_words   = '0;
        addr_match    = 1'b0;
        crc_lo        = '0;
        send_gap      = 0;
        recv_stall    = 0;
        rx_pushed     = 0;
        mismatches    = 0;
        on_boundary   = 1'b1;
        gap_max       = 6;
        stall_max     = 6;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_max   = (ph % 3 == 1) ? 0 : 6;
            stall_max = (ph % 4 == 2) ? 0 : 6;
            case (ph)
                0: ;  // run on the reset values
                1: begin
                    write_reg(REG_DEVICE_ID, 32'd0);
                    write_reg(REG_VOLTAGE_LIMIT, 32'd0);
                    write_reg(REG_CURRENT_LIMIT, 32'd0);
                    write_reg(REG_PF_MINIMUM, 32'd0);
                    write_reg(REG_FREQ_LOW, 32'd0);
                    write_reg(REG_FREQ_HIGH, 32'd0);
                    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(REG_DEVICE_ID, 32'hFFFF_FFFF);
                    write_reg(REG_VOLTAGE_LIMIT, 32'hFFFF_FFFF);
                    write_reg(REG_CURRENT_LIMIT, 32'hFFFF_FFFF);
                    write_reg(REG_PF_MINIMUM, 32'hFFFF_FFFF);
                    write_reg(REG_FREQ_LOW, 32'hFFFF_0000);
                    write_reg(REG_FREQ_HIGH, 32'hFFFF_FFFF);
                    write_reg(REG_SPARE_HI, 32'd0);
                end
                default: begin
                    write_reg(REG_DEVICE_ID, $urandom());
                    write_reg(REG_VOLTAGE_LIMIT,
                              $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 5000000));
                    write_reg(REG_CURRENT_LIMIT,
                              $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 500000));
                    write_reg(REG_PF_MINIMUM,
                              $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000));
                    lo = $urandom_range(0, 60000);
                    write_reg(REG_FREQ_LOW, lo);
                    write_reg(REG_FREQ_HIGH, ($urandom_range(0, 5) == 0) ?
                              $urandom_range(0, 65535) : lo + $urandom_range(2, 5000));
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
                end
            endcase

            if (ph == 0) begin
                base = {32'd5000, 32'd2500, 32'd0, 32'd950,
                        32'd123456, 32'd2200000, 32'd100000, 32'd2300000};
                push_frame(8'd1, base, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                // no start flag: relies on the count wrapping after the last byte
                w = base; w[0] = 32'd2600000;
                push_frame(8'd1, w, 16'h0000, 1'b0, 1'b0, FRAME_BYTES);
                w = base; w[0] = 32'd2599999; w[1] = 32'd200000;
                push_frame(8'd1, w, 16'h0000, 1'b0, 1'b0, FRAME_BYTES);
                w = base; w[1] = 32'd199999; w[4] = 32'd99;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[4] = 32'd100;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b1, FRAME_BYTES);
                push_frame(8'd0, base, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                push_frame(8'hFF, base, 16'h0101, 1'b1, 1'b0, FRAME_BYTES);
                push_frame(8'd1, base, 16'h0001, 1'b1, 1'b0, FRAME_BYTES);
                push_frame(8'd1, base, 16'h8000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[3] = 32'd0;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[0] = 32'd0; w[6] = 32'd0;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[6] = 32'd0;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[7] = 32'd4800;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[7] = 32'd5100;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[7] = 32'd4801;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = base; w[7] = 32'd5099;
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                push_frame(8'd1, '1, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                w = {32'd4900, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
                push_frame(8'd1, w, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
                // a frame cut short, then restarted by the start flag
                push_frame(8'd1, base, 16'h0000, 1'b1, 1'b0, 12);
                push_frame(8'd1, base, 16'h0000, 1'b1, 1'b0, FRAME_BYTES);
            end

            phase_start = rx_pushed;
            while (rx_pushed - phase_start < PHASE_BYTES) begin
                case ($urandom_range(0, 15))
                    9:  push_random_frame(F_BAD_ID, FRAME_BYTES);
                    10: push_random_frame(F_BAD_CRC, FRAME_BYTES);
                    11: push_random_frame(F_ZERO, FRAME_BYTES);
                    12: push_random_frame(F_RANGE, FRAME_BYTES);
                    13: push_random_frame(frame_kind_t'($urandom_range(0, 4)),
                                          $urandom_range(1, FRAME_BYTES - 1));
                    14: begin
                        n = $urandom_range(1, 40);
                        repeat (n) begin
                            req.data  = 8'($urandom());
                            req.start = ($urandom_range(0, 7) == 0);
                            req.drain = 1'b0;
                            rx_pending.push_back(req);
                        end
                        rx_pushed   += n;
                        on_boundary = 1'b0;
                    end
                    default: push_random_frame(F_GOOD, FRAME_BYTES);
                endcase
            end
            // end every phase on a whole frame so the count is back at zero
            push_random_frame(F_GOOD, FRAME_BYTES);
            wait_drained();
        end

        wait_drained();
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("meter_response_frame_checker regression: pass");
        end else begin
            $display("meter_response_frame_checker regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mrfc_pkg.sv
hdl/mrfc_frame_track.sv
hdl/mrfc_verdict.sv
hdl/meter_response_frame_checker.sv
tb/tb.sv
